[design/hbc_pkg.sv]
// shared types and constants for the hashed buffer cache tag table
package hbc_pkg;

   localparam int DEV_W      = 8;
   localparam int BLK_W      = 32;
   localparam int REF_W      = 8;
   localparam int TIME_W     = 32;
   localparam int SLOT_W     = 6;
   localparam int BKT_W      = 4;
   localparam int CMD_W      = 2;
   localparam int STAT_W     = 2;
   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 8;
   localparam int HASH_DIG_W = 4;

   localparam logic [REF_W-1:0] REF_MAX = 8'hFF;

   typedef enum logic [CMD_W-1:0] {
      CMD_GET     = 2'd0,
      CMD_RELEASE = 2'd1,
      CMD_PIN     = 2'd2,
      CMD_UNPIN   = 2'd3
   } hbc_cmd_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK     = 2'd0,
      STAT_NO_BUF = 2'd1,
      STAT_ZERO   = 2'd2
   } hbc_stat_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HASH,
      ST_SCAN,
      ST_COMMIT,
      ST_ENT_RD,
      ST_ENT_UPD,
      ST_RESP
   } hbc_state_type;

   typedef struct packed {
      logic [BKT_W-1:0]  bkt;
      logic              valid;
      logic [TIME_W-1:0] rtime;
      logic [REF_W-1:0]  cnt;
      logic [BLK_W-1:0]  blk;
      logic [DEV_W-1:0]  dev;
   } hbc_entry_type;

   typedef struct packed {
      logic             done;
      logic [BKT_W-1:0] rem;
   } hbc_mod_rsp_type;

endpackage

[design/hbc_mod.sv]
// block number to bucket reduction, four bits per cycle, most significant first
module hbc_mod #(
   parameter int DIVISOR = 13
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [31:0]             value,
   output hbc_pkg::hbc_mod_rsp_type result
);
   import hbc_pkg::*;

   localparam int STEPS  = 32 / HASH_DIG_W;
   localparam int STEP_W = $clog2(STEPS);

   logic [31:0]       val_ff;
   logic [BKT_W-1:0]  rem_ff;
   logic [BKT_W-1:0]  rem_in;
   logic [STEP_W-1:0] step_ff;
   logic              busy_ff;
   logic              done_ff;

   always_comb begin
      logic [BKT_W:0] r;
      r = {1'b0, rem_ff};
      for (int j = 0; j < HASH_DIG_W; j++) begin
         r = {r[BKT_W-1:0], val_ff[31-j]};
         if (r >= (BKT_W+1)'(DIVISOR)) begin
            r = r - (BKT_W+1)'(DIVISOR);
         end
      end
      rem_in = r[BKT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         val_ff <= value;
         rem_ff <= '0;
      end else if (busy_ff) begin
         val_ff <= val_ff << HASH_DIG_W;
         rem_ff <= rem_in;
      end
   end

   assign result.done = done_ff;
   assign result.rem  = rem_ff;

endmodule

[design/hashed_buffer_cache_lru.sv]
// hashed buffer cache tag table with reference counts and oldest-free replacement
// get: after the bucket reduction, the scan
//   reads the entry memory once per entry
// release, pin, unpin: read the entry, then update it (neither for an entry index beyond the table)
// one word in flight; the next word is taken once the result is registered
// reset clears per-entry init flags; an entry never written reads as its reset tag
module hashed_buffer_cache_lru #(
   parameter int NUM_BUCKETS     = 13,
   parameter int BUFS_PER_BUCKET = 3
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // dev, blockno, entry_index, now, zero pad
   input  logic [hbc_pkg::REQ_DATA_W-1:0]     req_tdata,
   // cmd
   input  logic [hbc_pkg::CMD_W-1:0]          req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // slot, hit, need_read
   output logic [hbc_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // status
   output logic [hbc_pkg::STAT_W-1:0]         rsp_tuser
);
   import hbc_pkg::*;

   localparam int NUM_ENTRIES = NUM_BUCKETS * BUFS_PER_BUCKET;
   localparam int IDX_W       = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
   localparam int SCAN_W      = $clog2(NUM_ENTRIES + 1);

   hbc_state_type state_ff, state_in;

   hbc_cmd_type       cmd_ff;
   logic [DEV_W-1:0]  dev_ff;
   logic [BLK_W-1:0]  blk_ff;
   logic [SLOT_W-1:0] ei_ff;
   logic [TIME_W-1:0] now_ff;

   hbc_entry_type     entry_mem [NUM_ENTRIES];
   hbc_entry_type     mem_q_ff;
   logic [IDX_W-1:0]  rd_idx_ff;
   logic [IDX_W-1:0]  rd_addr;
   logic              mem_we;
   logic [IDX_W-1:0]  mem_waddr;
   hbc_entry_type     mem_wdata;
   logic [NUM_ENTRIES-1:0] init_ff;

   logic [BLK_W-1:0]  home_blk [NUM_ENTRIES];
   hbc_entry_type     rst_rec;
   hbc_entry_type     eff_rec;

   logic [SCAN_W-1:0] scan_ff, scan_in;
   logic              chk_v_ff, chk_v_in;

   logic              hit_v_ff, hit_v_in;
   logic [IDX_W-1:0]  hit_idx_ff, hit_idx_in;
   hbc_entry_type     hit_rec_ff, hit_rec_in;
   logic              own_v_ff, own_v_in;
   logic [IDX_W-1:0]  own_idx_ff, own_idx_in;
   logic [TIME_W-1:0] own_time_ff, own_time_in;
   logic              any_v_ff, any_v_in;
   logic [IDX_W-1:0]  any_idx_ff, any_idx_in;
   logic [TIME_W-1:0] any_time_ff, any_time_in;

   logic [SLOT_W-1:0] res_slot_ff, res_slot_in;
   logic              res_hit_ff, res_hit_in;
   logic              res_need_ff, res_need_in;
   hbc_stat_type      res_stat_ff, res_stat_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0] rsp_slot_ff;
   logic              rsp_hit_ff;
   logic              rsp_need_ff;
   hbc_stat_type      rsp_stat_ff;
   logic              out_load;

   logic              mod_start;
   hbc_mod_rsp_type   mod_rsp;
   logic [BKT_W-1:0]  bucket;

   logic              req_acc;

   hbc_mod #(
      .DIVISOR (NUM_BUCKETS)
   ) u_mod (
      .clock  (clock),
      .reset  (reset),
      .start  (mod_start),
      .value  (req_tdata[39:8]),
      .result (mod_rsp)
   );

   assign bucket = mod_rsp.rem;

   for (genvar g = 0; g < NUM_ENTRIES; g++) begin : g_home
      assign home_blk[g] = BLK_W'(g / BUFS_PER_BUCKET);
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;

   // entry as seen through the init flags
   always_comb begin
      rst_rec.dev   = '0;
      rst_rec.blk   = home_blk[rd_idx_ff];
      rst_rec.cnt   = '0;
      rst_rec.rtime = '0;
      rst_rec.valid = 1'b0;
      rst_rec.bkt   = home_blk[rd_idx_ff][BKT_W-1:0];
      eff_rec       = init_ff[rd_idx_ff] ? mem_q_ff : rst_rec;
   end

   always_comb begin
      logic match;
      logic free;
      state_in    = state_ff;
      scan_in     = scan_ff;
      chk_v_in    = 1'b0;
      rd_addr     = rd_idx_ff;
      mem_we      = 1'b0;
      mem_waddr   = rd_idx_ff;
      mem_wdata   = eff_rec;
      mod_start   = 1'b0;
      out_load    = 1'b0;
      hit_v_in    = hit_v_ff;
      hit_idx_in  = hit_idx_ff;
      hit_rec_in  = hit_rec_ff;
      own_v_in    = own_v_ff;
      own_idx_in  = own_idx_ff;
      own_time_in = own_time_ff;
      any_v_in    = any_v_ff;
      any_idx_in  = any_idx_ff;
      any_time_in = any_time_ff;
      res_slot_in = res_slot_ff;
      res_hit_in  = res_hit_ff;
      res_need_in = res_need_ff;
      res_stat_in = res_stat_ff;

      // scan bookkeeping on returning read data
      match = (eff_rec.bkt == bucket) && (eff_rec.dev == dev_ff) && (eff_rec.blk == blk_ff);
      free  = (eff_rec.cnt == '0);
      if (chk_v_ff) begin
         if (match && !hit_v_ff) begin
            hit_v_in   = 1'b1;
            hit_idx_in = rd_idx_ff;
            hit_rec_in = eff_rec;
         end
         if (free && (eff_rec.bkt == bucket) && (!own_v_ff || (eff_rec.rtime < own_time_ff))) begin
            own_v_in    = 1'b1;
            own_idx_in  = rd_idx_ff;
            own_time_in = eff_rec.rtime;
         end
         if (free && (!any_v_ff || (eff_rec.rtime < any_time_ff))) begin
            any_v_in    = 1'b1;
            any_idx_in  = rd_idx_ff;
            any_time_in = eff_rec.rtime;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               res_hit_in  = 1'b0;
               res_need_in = 1'b0;
               res_stat_in = STAT_OK;
               res_slot_in = req_tdata[45:40];
               if (hbc_cmd_type'(req_tuser) == CMD_GET) begin
                  mod_start = 1'b1;
                  state_in  = ST_HASH;
               end else if (int'(req_tdata[45:40]) < NUM_ENTRIES) begin
                  state_in = ST_ENT_RD;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_HASH: begin
            if (mod_rsp.done) begin
               scan_in  = '0;
               hit_v_in = 1'b0;
               own_v_in = 1'b0;
               any_v_in = 1'b0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_ff < SCAN_W'(NUM_ENTRIES)) begin
               rd_addr  = scan_ff[IDX_W-1:0];
               chk_v_in = 1'b1;
               scan_in  = scan_ff + SCAN_W'(1);
            end else if (!chk_v_ff) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            res_stat_in = STAT_OK;
            if (hit_v_ff) begin
               mem_we          = 1'b1;
               mem_waddr       = hit_idx_ff;
               mem_wdata       = hit_rec_ff;
               mem_wdata.valid = 1'b1;
               if (hit_rec_ff.cnt != REF_MAX) begin
                  mem_wdata.cnt = hit_rec_ff.cnt + REF_W'(1);
               end
               res_slot_in = SLOT_W'(hit_idx_ff);
               res_hit_in  = 1'b1;
               res_need_in = !hit_rec_ff.valid;
            end else if (own_v_ff || any_v_ff) begin
               mem_we          = 1'b1;
               mem_waddr       = own_v_ff ? own_idx_ff : any_idx_ff;
               mem_wdata.bkt   = bucket;
               mem_wdata.valid = 1'b1;
               mem_wdata.rtime = own_v_ff ? own_time_ff : any_time_ff;
               mem_wdata.cnt   = REF_W'(1);
               mem_wdata.blk   = blk_ff;
               mem_wdata.dev   = dev_ff;
               res_slot_in     = SLOT_W'(own_v_ff ? own_idx_ff : any_idx_ff);
               res_hit_in      = 1'b0;
               res_need_in     = 1'b1;
            end else begin
               res_slot_in = '0;
               res_hit_in  = 1'b0;
               res_need_in = 1'b0;
               res_stat_in = STAT_NO_BUF;
            end
            state_in = ST_RESP;
         end
         ST_ENT_RD: begin
            rd_addr  = IDX_W'(ei_ff);
            state_in = ST_ENT_UPD;
         end
         ST_ENT_UPD: begin
            if (cmd_ff == CMD_PIN) begin
               mem_we = 1'b1;
               if (eff_rec.cnt != REF_MAX) begin
                  mem_wdata.cnt = eff_rec.cnt + REF_W'(1);
               end
            end else if (eff_rec.cnt == '0) begin
               res_stat_in = STAT_ZERO;
            end else begin
               mem_we        = 1'b1;
               mem_wdata.cnt = eff_rec.cnt - REF_W'(1);
               if ((cmd_ff == CMD_RELEASE) && (eff_rec.cnt == REF_W'(1))) begin
                  mem_wdata.rtime = now_ff;
               end
            end
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = out_load || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         scan_ff      <= '0;
         chk_v_ff     <= 1'b0;
         hit_v_ff     <= 1'b0;
         own_v_ff     <= 1'b0;
         any_v_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         init_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         chk_v_ff     <= chk_v_in;
         hit_v_ff     <= hit_v_in;
         own_v_ff     <= own_v_in;
         any_v_ff     <= any_v_in;
         rsp_valid_ff <= rsp_valid_in;
         if (mem_we) begin
            init_ff[mem_waddr] <= 1'b1;
         end
      end
   end

   // entry memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[mem_waddr] <= mem_wdata;
      end
      mem_q_ff  <= entry_mem[rd_addr];
      rd_idx_ff <= rd_addr;
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         cmd_ff <= hbc_cmd_type'(req_tuser);
         dev_ff <= req_tdata[7:0];
         blk_ff <= req_tdata[39:8];
         ei_ff  <= req_tdata[45:40];
         now_ff <= req_tdata[77:46];
      end
      hit_idx_ff  <= hit_idx_in;
      hit_rec_ff  <= hit_rec_in;
      own_idx_ff  <= own_idx_in;
      own_time_ff <= own_time_in;
      any_idx_ff  <= any_idx_in;
      any_time_ff <= any_time_in;
      res_slot_ff <= res_slot_in;
      res_hit_ff  <= res_hit_in;
      res_need_ff <= res_need_in;
      res_stat_ff <= res_stat_in;
      if (out_load) begin
         rsp_slot_ff <= res_slot_ff;
         rsp_hit_ff  <= res_hit_ff;
         rsp_need_ff <= res_need_ff;
         rsp_stat_ff <= res_stat_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_need_ff, rsp_hit_ff, rsp_slot_ff};
   assign rsp_tuser  = rsp_stat_ff;

   a_wr_range: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (int'(mem_waddr) < NUM_ENTRIES))
      else $error("entry write beyond table");

   a_one_word: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> !req_tready)
      else $error("second word taken while busy");

   a_own_any: assert property (@(posedge clock) disable iff (reset)
      own_v_ff |-> any_v_ff)
      else $error("own bucket victim without global victim");

   a_nobuf: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_stat_ff == STAT_NO_BUF)) |->
      (!rsp_hit_ff && !rsp_need_ff && (rsp_slot_ff == '0)))
      else $error("no buffer result carries an entry");

endmodule

[verif/hbc_checker.sv]
// result checker for the hashed buffer cache: tracks the tag table and compares every result word
module hbc_checker #(
   parameter int NUM_BUCKETS     = 13,
   parameter int BUFS_PER_BUCKET = 3
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   // dev, blockno, entry_index, now, zero pad
   input  logic [hbc_pkg::REQ_DATA_W-1:0] req_tdata,
   // cmd
   input  logic [hbc_pkg::CMD_W-1:0]      req_tuser,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // slot, hit, need_read
   input  logic [hbc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // status
   input  logic [hbc_pkg::STAT_W-1:0]     rsp_tuser,
   output int                             fail_count,
   output int                             pending
);
   import hbc_pkg::*;

   localparam int NUM_ENTRIES = NUM_BUCKETS * BUFS_PER_BUCKET;

   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      logic              hit;
      logic              need_read;
      hbc_stat_type      status;
   } cache_rsp_type;

   logic [DEV_W-1:0]  tag_dev   [NUM_ENTRIES];
   logic [BLK_W-1:0]  tag_blk   [NUM_ENTRIES];
   logic [REF_W-1:0]  ref_cnt   [NUM_ENTRIES];
   logic [TIME_W-1:0] rel_time  [NUM_ENTRIES];
   logic              loaded    [NUM_ENTRIES];
   logic [BKT_W-1:0]  bkt_of    [NUM_ENTRIES];

   cache_rsp_type due_rsp_q [$];

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   function automatic int oldest_free(input bit own_only, input logic [BKT_W-1:0] bkt);
      int best;
      best = -1;
      for (int i = 0; i < NUM_ENTRIES; i++) begin
         if (ref_cnt[i] == '0) begin
            if (!own_only || bkt_of[i] == bkt) begin
               if (best < 0 || rel_time[i] < rel_time[best]) begin
                  best = i;
               end
            end
         end
      end
      return best;
   endfunction

   function automatic cache_rsp_type cache_response(input hbc_cmd_type cmd,
                                                    input logic [DEV_W-1:0] dev,
                                                    input logic [BLK_W-1:0] blk,
                                                    input logic [SLOT_W-1:0] ei,
                                                    input logic [TIME_W-1:0] now);
      cache_rsp_type res;
      int found;
      logic [BKT_W-1:0] bkt;
      res.slot      = '0;
      res.hit       = 1'b0;
      res.need_read = 1'b0;
      res.status    = STAT_OK;
      if (cmd == CMD_GET) begin
         bkt   = BKT_W'(blk % 32'(NUM_BUCKETS));
         found = -1;
         for (int i = 0; i < NUM_ENTRIES; i++) begin
            if (found < 0 && bkt_of[i] == bkt && tag_dev[i] == dev && tag_blk[i] == blk) begin
               found = i;
            end
         end
         if (found >= 0) begin
            res.hit = 1'b1;
            if (ref_cnt[found] != REF_MAX) begin
               ref_cnt[found] = ref_cnt[found] + 1'b1;
            end
         end else begin
            found = oldest_free(1'b1, bkt);
            if (found < 0) begin
               found = oldest_free(1'b0, bkt);
            end
            if (found >= 0) begin
               bkt_of[found]  = bkt;
               tag_dev[found] = dev;
               tag_blk[found] = blk;
               loaded[found]  = 1'b0;
               ref_cnt[found] = REF_W'(1);
            end
         end
         if (found < 0) begin
            res.status = STAT_NO_BUF;
         end else begin
            res.slot      = SLOT_W'(found);
            res.need_read = !loaded[found];
            loaded[found] = 1'b1;
         end
      end else begin
         res.slot = ei;
         if (ei < NUM_ENTRIES) begin
            if (cmd == CMD_PIN) begin
               if (ref_cnt[ei] != REF_MAX) begin
                  ref_cnt[ei] = ref_cnt[ei] + 1'b1;
               end
            end else if (ref_cnt[ei] == '0) begin
               res.status = STAT_ZERO;
            end else begin
               ref_cnt[ei] = ref_cnt[ei] - 1'b1;
               if (cmd == CMD_RELEASE && ref_cnt[ei] == '0) begin
                  rel_time[ei] = now;
               end
            end
         end
      end
      return res;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin : watch
      cache_rsp_type want;
      if (reset) begin
         for (int i = 0; i < NUM_ENTRIES; i++) begin
            tag_dev[i]  = '0;
            tag_blk[i]  = BLK_W'(i / BUFS_PER_BUCKET);
            ref_cnt[i]  = '0;
            rel_time[i] = '0;
            loaded[i]   = 1'b0;
            bkt_of[i]   = BKT_W'(i / BUFS_PER_BUCKET);
         end
         due_rsp_q.delete();
      end else begin
         if (rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
            if (due_rsp_q.size() == 0) begin
               $display("%0t: unexpected result word, expected none, actual slot %0d status %0d",
                        $time, rsp_tdata[5:0], rsp_tuser);
               fail_count++;
            end else begin
               want = due_rsp_q.pop_front();
               check_field("slot", 32'(want.slot), 32'(rsp_tdata[5:0]));
               check_field("hit", 32'(want.hit), 32'(rsp_tdata[6]));
               check_field("need_read", 32'(want.need_read), 32'(rsp_tdata[7]));
               check_field("status", 32'(want.status), 32'(rsp_tuser));
            end
         end
         if (req_tvalid === 1'b1 && req_tready === 1'b1) begin
            due_rsp_q.push_back(cache_response(hbc_cmd_type'(req_tuser), req_tdata[7:0],
                                               req_tdata[39:8], req_tdata[45:40],
                                               req_tdata[77:46]));
         end
      end
      pending = due_rsp_q.size();
   end

endmodule

[verif/tb.sv]
// stimulus and verdict for the hashed buffer cache tag table
module tb;
   import hbc_pkg::*;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [CMD_W-1:0]      req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [STAT_W-1:0]     rsp_tuser;

   int fail_count;
   int pending;
   int tx_idle_pct = 17;
   int rx_idle_pct = 73;
   int rx_hold_len = 0;
   logic [TIME_W-1:0] tick = '0;

   hashed_buffer_cache_lru uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   hbc_checker rsp_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #14400000;
      $display("CHECKS FAILED");
      $finish;
   end

   // receiver: random backpressure, or a long hold when asked
   initial begin : receiver
      int hold_left;
      forever begin
         @(negedge clock);
         if (rx_hold_len > 0) begin
            rsp_tready <= 1'b0;
            for (hold_left = rx_hold_len; hold_left > 0; hold_left--) begin
               @(negedge clock);
            end
            rx_hold_len = 0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   task automatic send_word(input hbc_cmd_type cmd, input logic [DEV_W-1:0] dev,
                            input logic [BLK_W-1:0] blk, input logic [SLOT_W-1:0] ei,
                            input logic [TIME_W-1:0] now);
      int gap;
      gap = 0;
      while ($urandom_range(99) < tx_idle_pct && gap < 40) begin
         gap++;
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {2'b00, now, ei, blk, dev};
      do @(posedge clock); while (req_tready !== 1'b1);
      @(negedge clock);
   endtask

   task automatic random_word(input bit filling);
      int r;
      hbc_cmd_type cmd;
      logic [DEV_W-1:0] dev;
      logic [BLK_W-1:0] blk;
      logic [SLOT_W-1:0] ei;
      logic [TIME_W-1:0] now;
      r = $urandom_range(99);
      if (filling) begin
         if (r < 70) cmd = CMD_GET;
         else if (r < 82) cmd = CMD_RELEASE;
         else if (r < 92) cmd = CMD_PIN;
         else cmd = CMD_UNPIN;
      end else begin
         if (r < 25) cmd = CMD_GET;
         else if (r < 70) cmd = CMD_RELEASE;
         else if (r < 80) cmd = CMD_PIN;
         else cmd = CMD_UNPIN;
      end
      if ($urandom_range(3) != 0) begin
         dev = DEV_W'($urandom_range(3));
         blk = BLK_W'($urandom_range(45));
      end else begin
         dev = DEV_W'($urandom);
         blk = $urandom;
      end
      if ($urandom_range(19) == 0) ei = SLOT_W'($urandom_range(63, 39));
      else ei = SLOT_W'($urandom_range(38));
      if ($urandom_range(4) != 0) begin
         tick = tick + $urandom_range(300);
         now  = tick;
      end else begin
         now = $urandom;
      end
      send_word(cmd, dev, blk, ei, now);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   initial begin : stimulus
      int n;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // reset tags hit, lowest match wins, counts at zero, indexes beyond the table
      send_word(CMD_GET, 8'd0, 32'd0, 6'd0, 32'd0);
      send_word(CMD_GET, 8'd0, 32'd0, 6'd63, 32'hFFFF_FFFF);
      send_word(CMD_GET, 8'd0, 32'd13, 6'd0, 32'd0);
      send_word(CMD_GET, 8'd255, 32'hFFFF_FFFF, 6'd38, 32'd5);
      send_word(CMD_GET, 8'd1, 32'd1, 6'd0, 32'd0);
      send_word(CMD_GET, 8'd0, 32'd1, 6'd0, 32'd0);
      send_word(CMD_RELEASE, 8'd0, 32'd0, 6'd3, 32'hFFFF_FFFF);
      send_word(CMD_RELEASE, 8'd0, 32'd0, 6'd3, 32'd7);
      send_word(CMD_UNPIN, 8'd0, 32'd0, 6'd3, 32'd0);
      send_word(CMD_PIN, 8'd0, 32'd0, 6'd3, 32'd0);
      send_word(CMD_UNPIN, 8'd0, 32'd0, 6'd3, 32'd9);
      send_word(CMD_RELEASE, 8'hAA, 32'h5555_5555, 6'd63, 32'd1);
      send_word(CMD_PIN, 8'd0, 32'd0, 6'd39, 32'd0);
      send_word(CMD_UNPIN, 8'd0, 32'd0, 6'd50, 32'd0);
      // own bucket full, victim taken from another bucket
      send_word(CMD_GET, 8'd2, 32'd2, 6'd0, 32'd0);
      send_word(CMD_GET, 8'd2, 32'd15, 6'd0, 32'd0);
      send_word(CMD_GET, 8'd2, 32'd28, 6'd0, 32'd0);
      send_word(CMD_GET, 8'd2, 32'd41, 6'd0, 32'd0);
      send_word(CMD_RELEASE, 8'd0, 32'd0, 6'd6, 32'd100);
      send_word(CMD_RELEASE, 8'd0, 32'd0, 6'd7, 32'd100);
      send_word(CMD_GET, 8'd3, 32'd2, 6'd0, 32'd0);

      // count saturation through pin and get hit, then drain to zero
      for (n = 0; n < 128; n++) send_word(CMD_PIN, 8'd0, 32'd0, 6'd0, 32'd0);
      for (n = 0; n < 130; n++) send_word(CMD_GET, 8'd0, 32'd0, 6'd0, 32'd0);
      for (n = 0; n < 3; n++) send_word(CMD_PIN, 8'd0, 32'd0, 6'd0, 32'd0);
      for (n = 0; n < 265; n++) begin
         tick = tick + $urandom_range(3);
         send_word(CMD_RELEASE, 8'd0, 32'd0, 6'd0, tick);
      end

      for (n = 0; n < 340; n++) random_word(((n / 60) % 2) == 0);
      wait_drained();
      repeat (20) @(negedge clock);

      tx_idle_pct = 73;
      rx_idle_pct = 17;
      for (n = 0; n < 345; n++) random_word(((n / 60) % 2) == 0);
      wait_drained();

      tx_idle_pct = 0;
      rx_idle_pct = 0;
      rx_hold_len = 400;
      for (n = 0; n < 345; n++) random_word(((n / 60) % 2) == 0);
      req_tvalid <= 1'b0;

      wait_drained();
      repeat (60) @(negedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

[sim.f]
design/hbc_pkg.sv
design/hbc_mod.sv
design/hashed_buffer_cache_lru.sv
verif/hbc_checker.sv
verif/tb.sv
